FILE: sv/mcss_pkg.sv
package mcss_pkg;

    localparam int COEF_W   = 32;
    localparam int ACC_W    = 40;
    localparam int LEN_W    = 7;
    localparam int ORDER_W  = 6;
    localparam int ALPHA_W  = 16;
    localparam int THR_W    = 31;
    localparam int RATIO_W  = 31;
    localparam int PWR_W    = 32;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;
    localparam int FIFO_DEPTH = 2;

    // register indexes (byte address 4*index)
    localparam logic [1:0] REG_FILTER_ORDER   = 2'd0;
    localparam logic [1:0] REG_WARP_ALPHA     = 2'd1;
    localparam logic [1:0] REG_PEAK_THRESHOLD = 2'd2;

    localparam logic [ORDER_W-1:0]        RST_FILTER_ORDER   = 6'd25;
    localparam logic signed [ALPHA_W-1:0] RST_WARP_ALPHA     = 16'sd13763;
    localparam logic [THR_W-1:0]          RST_PEAK_THRESHOLD = 31'd4194304;

    localparam logic signed [PWR_W-1:0] Q30_ONE = 32'sh4000_0000;

    localparam logic signed [42:0] S32_MAX = 43'sd2147483647;
    localparam logic signed [42:0] S32_MIN = -43'sd2147483648;
    localparam logic signed [ACC_W:0] S40_MAX = 41'sd549755813887;
    localparam logic signed [ACC_W:0] S40_MIN = -41'sd549755813888;

    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic signed [ACC_W-1:0]  acc_t;

    typedef struct packed {
        logic             bank;
        logic [LEN_W-1:0] len;
        acc_t             sum;
        acc_t             gain;
    } frame_desc_t;

    function automatic acc_t sat40(input logic signed [ACC_W:0] v);
        acc_t r;
        if (v > S40_MAX) begin
            r = S40_MAX[ACC_W-1:0];
        end else if (v < S40_MIN) begin
            r = S40_MIN[ACC_W-1:0];
        end else begin
            r = v[ACC_W-1:0];
        end
        return r;
    endfunction

    function automatic coef_t sat32(input logic signed [42:0] v);
        coef_t r;
        if (v > S32_MAX) begin
            r = S32_MAX[COEF_W-1:0];
        end else if (v < S32_MIN) begin
            r = S32_MIN[COEF_W-1:0];
        end else begin
            r = v[COEF_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: sv/mcss_ram.sv
module mcss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

FILE: sv/mcss_front.sv
module mcss_front #(
    parameter int MAX_COEFFICIENTS = 64,
    localparam int LEN_CAP = (MAX_COEFFICIENTS < 64) ? MAX_COEFFICIENTS : 64,
    localparam int BANK_AW = $clog2(LEN_CAP)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  mcss_pkg::coef_t       s_coefficient,
    input  logic [5:0]            filter_order,
    input  logic signed [15:0]    warp_alpha,
    input  logic                  cfg_clear,
    input  logic                  fifo_full,
    output logic                  push,
    output mcss_pkg::frame_desc_t push_desc,
    output logic                  mem_we,
    output logic [BANK_AW:0]      mem_waddr,
    output mcss_pkg::coef_t       mem_wdata
);

    import mcss_pkg::*;

    logic                     busy_reg;
    logic [LEN_W-1:0]         load_count_reg;
    logic signed [PWR_W-1:0]  alpha_power_reg;
    acc_t                     sum_reg;
    acc_t                     gain_reg;
    logic                     wr_bank_reg;
    coef_t                    coef_reg;
    logic signed [63:0]       prod_gain_reg;
    logic signed [48:0]       prod_pow_reg;

    logic [LEN_W-1:0]         order_plus1;
    logic [LEN_W-1:0]         frame_len;
    logic [LEN_W-1:0]         load_count_next;
    logic signed [16:0]       neg_alpha;
    logic signed [63:0]       gain_round;
    logic signed [48:0]       pow_round;
    acc_t                     sum_next;
    acc_t                     gain_next;
    logic signed [PWR_W-1:0]  power_next;
    logic                     accept;
    logic                     frame_done;

    always_comb begin
        order_plus1     = {1'b0, filter_order} + 7'd1;
        frame_len       = (order_plus1 > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : order_plus1;
        load_count_next = load_count_reg + 7'd1;
        neg_alpha       = -{warp_alpha[15], warp_alpha};
        gain_round      = prod_gain_reg + 64'sd536870912;
        pow_round       = prod_pow_reg + 49'sd16384;
        sum_next        = sat40(41'(sum_reg) + 41'(coef_reg));
        gain_next       = sat40(41'(gain_reg) + 41'($signed(gain_round[63:30])));
        power_next      = sat32(43'($signed(pow_round[48:15])));
    end

    assign s_ready    = !busy_reg && !fifo_full;
    assign accept     = s_valid && s_ready;
    assign frame_done = busy_reg && (load_count_next == frame_len);

    assign push      = frame_done;
    assign push_desc = '{bank: wr_bank_reg, len: frame_len, sum: sum_next, gain: gain_next};

    assign mem_we    = accept;
    assign mem_waddr = {wr_bank_reg, load_count_reg[BANK_AW-1:0]};
    assign mem_wdata = s_coefficient;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg        <= 1'b0;
            load_count_reg  <= '0;
            alpha_power_reg <= Q30_ONE;
            sum_reg         <= '0;
            gain_reg        <= '0;
            wr_bank_reg     <= 1'b0;
        end else if (cfg_clear) begin
            // drop any partly loaded frame
            busy_reg        <= 1'b0;
            load_count_reg  <= '0;
            alpha_power_reg <= Q30_ONE;
            sum_reg         <= '0;
            gain_reg        <= '0;
        end else if (accept) begin
            busy_reg <= 1'b1;
        end else if (busy_reg) begin
            busy_reg <= 1'b0;
            if (frame_done) begin
                load_count_reg  <= '0;
                alpha_power_reg <= Q30_ONE;
                sum_reg         <= '0;
                gain_reg        <= '0;
                wr_bank_reg     <= !wr_bank_reg;
            end else begin
                load_count_reg  <= load_count_next;
                alpha_power_reg <= power_next;
                sum_reg         <= sum_next;
                gain_reg        <= gain_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            coef_reg      <= s_coefficient;
            prod_gain_reg <= s_coefficient * alpha_power_reg;
            prod_pow_reg  <= alpha_power_reg * neg_alpha;
        end
    end

    a_accept_then_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !cfg_clear) |=> (busy_reg && !s_ready))
        else $error("front took an item without entering its finish cycle");

endmodule

FILE: sv/mcss_frame_fifo.sv
module mcss_frame_fifo (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  mcss_pkg::frame_desc_t push_desc,
    output logic                  full,
    input  logic                  pop,
    output mcss_pkg::frame_desc_t head_desc,
    output logic                  empty
);

    import mcss_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);

    frame_desc_t      entry_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;

    assign full      = (count_reg == (PTR_W + 1)'(FIFO_DEPTH));
    assign empty     = (count_reg == '0);
    assign head_desc = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (!full || pop))
        else $error("frame queue written while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("frame queue read while empty");

endmodule

FILE: sv/mcss_back.sv
module mcss_back #(
    parameter int MAX_COEFFICIENTS = 64,
    localparam int LEN_CAP = (MAX_COEFFICIENTS < 64) ? MAX_COEFFICIENTS : 64,
    localparam int BANK_AW = $clog2(LEN_CAP)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [30:0]           peak_threshold,
    input  logic                  fifo_empty,
    input  mcss_pkg::frame_desc_t head_desc,
    output logic                  pop,
    output logic [BANK_AW:0]      mem_raddr,
    input  mcss_pkg::coef_t       mem_rdata,
    output logic                  m_valid,
    input  logic                  m_ready,
    output mcss_pkg::coef_t       m_coefficient_out,
    output logic [5:0]            m_coefficient_index,
    output logic                  m_is_last,
    output logic                  m_stable,
    output mcss_pkg::coef_t       m_peak_amplitude
);

    import mcss_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PEAK = 3'd1;
    localparam logic [2:0] S_CMP  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_RD   = 3'd4;
    localparam logic [2:0] S_MUL  = 3'd5;
    localparam logic [2:0] S_SUM  = 3'd6;
    localparam logic [2:0] S_FIN  = 3'd7;

    logic [2:0]              state_reg;
    logic                    m_valid_reg;
    logic                    bank_reg;
    logic [LEN_W-1:0]        len_reg;
    acc_t                    sum_reg;
    acc_t                    gain_reg;
    coef_t                   peak_reg;
    logic                    stable_reg;
    logic [31:0]             rem_reg;
    logic [RATIO_W-1:0]      ratio_reg;
    logic [4:0]              div_cnt_reg;
    logic [LEN_W-1:0]        emit_cnt_reg;
    coef_t                   coef_reg;
    logic signed [56:0]      prod_hi_reg;
    logic signed [57:0]      prod_lo_reg;
    logic signed [72:0]      acc_reg;
    coef_t                   out_coef_reg;
    logic [5:0]              out_index_reg;
    logic                    out_last_reg;
    logic                    out_stable_reg;
    coef_t                   out_peak_reg;

    coef_t                   peak_sat;
    logic                    thr_ok;
    logic [32:0]             rem_shift;
    logic [32:0]             rem_sub;
    logic                    rem_ge;
    logic                    first;
    logic                    last;
    logic signed [40:0]      diff_in;
    logic signed [72:0]      acc_next;
    coef_t                   scaled;
    coef_t                   out_value;
    logic                    out_free;

    always_comb begin
        peak_sat  = sat32(43'(sum_reg) - 43'(gain_reg));
        thr_ok    = (peak_reg <= $signed({1'b0, peak_threshold}));
        rem_shift = {rem_reg, 1'b0};
        rem_sub   = rem_shift - {1'b0, peak_reg};
        rem_ge    = (rem_shift >= {1'b0, peak_reg});
        first     = (emit_cnt_reg == '0);
        last      = ((emit_cnt_reg + 7'd1) == len_reg);
        // c0 is scaled about the gain
        diff_in   = first ? (41'(mem_rdata) - 41'(gain_reg)) : 41'(mem_rdata);
        acc_next  = $signed({prod_hi_reg, 16'b0})
                  + $signed({{15{prod_lo_reg[57]}}, prod_lo_reg})
                  + $signed({43'd1, 30'd0});
        scaled    = sat32(43'($signed(acc_reg[72:31]))
                  + (first ? 43'(gain_reg) : 43'sd0));
        out_value = stable_reg ? coef_reg : scaled;
        out_free  = !m_valid_reg || m_ready;
    end

    assign pop       = (state_reg == S_FIN) && out_free && last;
    assign mem_raddr = {bank_reg, emit_cnt_reg[BANK_AW-1:0]};

    assign m_valid             = m_valid_reg;
    assign m_coefficient_out   = out_coef_reg;
    assign m_coefficient_index = out_index_reg;
    assign m_is_last           = out_last_reg;
    assign m_stable            = out_stable_reg;
    assign m_peak_amplitude    = out_peak_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if ((state_reg == S_FIN) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (!fifo_empty) begin
                        state_reg <= S_PEAK;
                    end
                end
                S_PEAK: state_reg <= S_CMP;
                S_CMP: begin
                    if ((len_reg == 7'd1) || thr_ok) begin
                        state_reg <= S_RD;
                    end else begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_cnt_reg == 5'(RATIO_W - 1)) begin
                        state_reg <= S_RD;
                    end
                end
                S_RD:  state_reg <= S_MUL;
                S_MUL: state_reg <= S_SUM;
                S_SUM: state_reg <= S_FIN;
                S_FIN: begin
                    if (out_free) begin
                        state_reg <= last ? S_IDLE : S_RD;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                bank_reg <= head_desc.bank;
                len_reg  <= head_desc.len;
                sum_reg  <= head_desc.sum;
                gain_reg <= head_desc.gain;
            end
            S_PEAK: peak_reg <= peak_sat;
            S_CMP: begin
                emit_cnt_reg <= '0;
                rem_reg      <= {1'b0, peak_threshold};
                ratio_reg    <= '0;
                div_cnt_reg  <= '0;
                if (len_reg == 7'd1) begin
                    // single coefficient: pass through with zero peak
                    peak_reg   <= '0;
                    stable_reg <= 1'b1;
                end else begin
                    stable_reg <= thr_ok;
                end
            end
            S_DIV: begin
                rem_reg     <= rem_ge ? rem_sub[31:0] : rem_shift[31:0];
                ratio_reg   <= {ratio_reg[RATIO_W-2:0], rem_ge};
                div_cnt_reg <= div_cnt_reg + 5'd1;
            end
            S_MUL: begin
                coef_reg    <= mem_rdata;
                prod_hi_reg <= diff_in * $signed({1'b0, ratio_reg[30:16]});
                prod_lo_reg <= diff_in * $signed({1'b0, ratio_reg[15:0]});
            end
            S_SUM: acc_reg <= acc_next;
            S_FIN: begin
                if (out_free) begin
                    out_coef_reg   <= out_value;
                    out_index_reg  <= emit_cnt_reg[5:0];
                    out_last_reg   <= last;
                    out_stable_reg <= stable_reg;
                    out_peak_reg   <= peak_reg;
                    emit_cnt_reg   <= emit_cnt_reg + 7'd1;
                end
            end
            default: ;
        endcase
    end

    a_div_only_unstable: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV) |-> (!stable_reg && peak_reg > $signed({1'b0, peak_threshold})))
        else $error("divider running on a frame within threshold");

    a_pop_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> (m_valid && m_is_last))
        else $error("frame released without its last result");

endmodule

FILE: sv/mel_cepstrum_stability_scaler.sv
// Channel | Direction | Handshake          | Payload
// s_      | in        | s_valid / s_ready  | s_coefficient
// m_      | out       | m_valid / m_ready  | m_coefficient_out, m_coefficient_index, m_is_last,
//         |           |                    | m_stable, m_peak_amplitude
// apb     | in        | psel/penable/pready| paddr, pwdata, pwrite, prdata
//
// Each coefficient is multiplied, then rounded and accumulated, before another is taken.
// Per frame the back end checks the peak and runs the bit-serial divider when the peak
// exceeds the threshold, then per result does a RAM read, two-part multiply and sum.
// A two-entry frame queue and a two-bank coefficient RAM let the next frame load while
// the previous one is emitted; loading stalls only when both banks are taken.
// Reset is synchronous, active low; no clearing pass is needed.
module mel_cepstrum_stability_scaler #(
    parameter int MAX_COEFFICIENTS = 64
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  mcss_pkg::coef_t             s_coefficient,
    output logic                        m_valid,
    input  logic                        m_ready,
    output mcss_pkg::coef_t             m_coefficient_out,
    output logic [5:0]                  m_coefficient_index,
    output logic                        m_is_last,
    output logic                        m_stable,
    output mcss_pkg::coef_t             m_peak_amplitude,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mcss_pkg::ADDR_W-1:0] paddr,
    input  logic [mcss_pkg::DATA_W-1:0] pwdata,
    output logic [mcss_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);

    import mcss_pkg::*;

    localparam int LEN_CAP   = (MAX_COEFFICIENTS < 64) ? MAX_COEFFICIENTS : 64;
    localparam int BANK_AW   = $clog2(LEN_CAP);
    localparam int MEM_DEPTH = 2 << BANK_AW;

    logic [ORDER_W-1:0]        filter_order_reg;
    logic signed [ALPHA_W-1:0] warp_alpha_reg;
    logic [THR_W-1:0]          peak_threshold_reg;

    logic                      cfg_write;
    logic                      cfg_clear;
    logic [1:0]                reg_idx;

    logic                      push;
    logic                      pop;
    logic                      fifo_full;
    logic                      fifo_empty;
    frame_desc_t               push_desc;
    frame_desc_t               head_desc;
    logic                      mem_we;
    logic [BANK_AW:0]          mem_waddr;
    logic [BANK_AW:0]          mem_raddr;
    coef_t                     mem_wdata;
    coef_t                     mem_rdata;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[3:2];
    assign cfg_write = psel && penable && pwrite;

    always_comb begin
        cfg_clear = 1'b0;
        prdata    = '0;
        unique case (reg_idx)
            REG_FILTER_ORDER: begin
                cfg_clear = cfg_write;
                prdata    = {26'd0, filter_order_reg};
            end
            REG_WARP_ALPHA: begin
                cfg_clear = cfg_write;
                prdata    = {{16{warp_alpha_reg[15]}}, warp_alpha_reg};
            end
            REG_PEAK_THRESHOLD: begin
                cfg_clear = cfg_write;
                prdata    = {1'b0, peak_threshold_reg};
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filter_order_reg   <= RST_FILTER_ORDER;
            warp_alpha_reg     <= RST_WARP_ALPHA;
            peak_threshold_reg <= RST_PEAK_THRESHOLD;
        end else if (cfg_write) begin
            unique case (reg_idx)
                REG_FILTER_ORDER:   filter_order_reg   <= pwdata[ORDER_W-1:0];
                REG_WARP_ALPHA:     warp_alpha_reg     <= pwdata[ALPHA_W-1:0];
                REG_PEAK_THRESHOLD: peak_threshold_reg <= pwdata[THR_W-1:0];
                default: ;
            endcase
        end
    end

    mcss_ram #(
        .WIDTH (COEF_W),
        .DEPTH (MEM_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    mcss_front #(
        .MAX_COEFFICIENTS (MAX_COEFFICIENTS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_coefficient (s_coefficient),
        .filter_order  (filter_order_reg),
        .warp_alpha    (warp_alpha_reg),
        .cfg_clear     (cfg_clear),
        .fifo_full     (fifo_full),
        .push          (push),
        .push_desc     (push_desc),
        .mem_we        (mem_we),
        .mem_waddr     (mem_waddr),
        .mem_wdata     (mem_wdata)
    );

    mcss_frame_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_desc (push_desc),
        .full      (fifo_full),
        .pop       (pop),
        .head_desc (head_desc),
        .empty     (fifo_empty)
    );

    mcss_back #(
        .MAX_COEFFICIENTS (MAX_COEFFICIENTS)
    ) u_back (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .peak_threshold      (peak_threshold_reg),
        .fifo_empty          (fifo_empty),
        .head_desc           (head_desc),
        .pop                 (pop),
        .mem_raddr           (mem_raddr),
        .mem_rdata           (mem_rdata),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_coefficient_out   (m_coefficient_out),
        .m_coefficient_index (m_coefficient_index),
        .m_is_last           (m_is_last),
        .m_stable            (m_stable),
        .m_peak_amplitude    (m_peak_amplitude)
    );

endmodule

FILE: tb/mel_cepstrum_stability_scaler_tb.sv
`timescale 1ns / 1ps

module mel_cepstrum_stability_scaler_tb;
    import mcss_pkg::*;

    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 400;
    localparam int TAIL_CYCLES   = 300;
    localparam int STORE_DEPTH   = 64;

    typedef struct packed {
        coef_t      value;
        logic [5:0] index;
        logic       last;
        logic       stable;
        coef_t      peak;
    } scaled_coef_t;

    typedef enum logic {ROW_WRITE, ROW_COEF} row_kind_t;

    typedef struct packed {
        row_kind_t    kind;
        logic [1:0]   reg_index;
        logic [31:0]  value;
        logic         fixed;
        scaled_coef_t want;
    } stim_row_t;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    coef_t               s_coefficient;
    logic                m_valid;
    logic                m_ready;
    coef_t               m_coefficient_out;
    logic [5:0]          m_coefficient_index;
    logic                m_is_last;
    logic                m_stable;
    coef_t               m_peak_amplitude;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    mel_cepstrum_stability_scaler uut (.*);

    always #6 aclk = ~aclk;

    // predictor state
    coef_t                frame_store [STORE_DEPTH];
    int                   frame_fill;
    longint               warp_power;
    longint               gain_sum;
    longint               coef_sum;
    logic [30:0]          ratio_q31;
    logic                 frame_ok;
    logic [5:0]           order_reg;
    logic signed [15:0]   alpha_reg;
    logic [30:0]          threshold_reg;

    scaled_coef_t frame_emission [$];
    scaled_coef_t awaited_coefficients [$];
    stim_row_t    directed_rows [$];

    int mismatch_count = 0;
    int s_idle_pct;
    int r_idle_pct;
    bit hold_request;

    function automatic longint saturate(longint v, int bits);
        longint hi;
        hi = (longint'(1) << (bits - 1)) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    // d * r / 2^31, rounded half up, split so no product overflows
    function automatic longint rescale(longint d, logic [30:0] r);
        longint upper;
        longint lower;
        upper = d * longint'(r[30:16]);
        lower = d * longint'(r[15:0]) + (longint'(1) << 30);
        return (upper + (lower >>> 16)) >>> 15;
    endfunction

    function automatic void restart_frame();
        frame_fill = 0;
        warp_power = longint'(Q30_ONE);
        gain_sum   = 0;
        coef_sum   = 0;
    endfunction

    function automatic void mirror_register_write(logic [1:0] idx, logic [31:0] v);
        case (idx)
            REG_FILTER_ORDER:   order_reg = v[5:0];
            REG_WARP_ALPHA:     alpha_reg = v[15:0];
            REG_PEAK_THRESHOLD: threshold_reg = v[30:0];
            default: return;
        endcase
        restart_frame();
    endfunction

    // Absorb one coefficient; on the last one of a frame, fill frame_emission.
    function automatic void load_and_scale(coef_t c);
        longint       cv;
        longint       peak;
        longint       v;
        int           count;
        scaled_coef_t r;
        frame_emission.delete();
        count = int'(order_reg) + 1;
        if (frame_fill >= count) restart_frame();
        cv = longint'(c);
        frame_store[frame_fill] = c;
        coef_sum = saturate(coef_sum + cv, 40);
        gain_sum = saturate(gain_sum + ((cv * warp_power + (longint'(1) << 29)) >>> 30), 40);
        warp_power = saturate((warp_power * -longint'(alpha_reg) + (longint'(1) << 14)) >>> 15,
                              32);
        frame_fill++;
        if (frame_fill < count) return;
        if (count == 1) begin
            peak = 0;
            frame_ok = 1'b1;
        end else begin
            peak = saturate(coef_sum - gain_sum, 32);
            frame_ok = (peak <= longint'(threshold_reg));
            if (!frame_ok) ratio_q31 = 31'((longint'(threshold_reg) << 31) / peak);
        end
        for (int m = 0; m < count; m++) begin
            v = longint'(frame_store[m]);
            if (!frame_ok) begin
                if (m == 0) v = saturate(rescale(v - gain_sum, ratio_q31) + gain_sum, 32);
                else v = saturate(rescale(v, ratio_q31), 32);
            end
            r.value  = coef_t'(v);
            r.index  = 6'(m);
            r.last   = (m == count - 1);
            r.stable = frame_ok;
            r.peak   = coef_t'(peak);
            frame_emission.push_back(r);
        end
        restart_frame();
    endfunction

    function automatic coef_t draw_coefficient();
        case ($urandom_range(7))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2, 3: return coef_t'($urandom());
            default: return coef_t'(int'($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
        endcase
    endfunction

    function automatic void add_write(logic [1:0] idx, logic [31:0] v);
        stim_row_t row;
        row = '0;
        row.kind = ROW_WRITE;
        row.reg_index = idx;
        row.value = v;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_coef(coef_t v);
        stim_row_t row;
        row = '0;
        row.kind = ROW_COEF;
        row.value = v;
        directed_rows.push_back(row);
    endfunction

    // single-coefficient frame with its result written out by hand
    function automatic void add_fixed(coef_t v, coef_t want_out, logic want_stable,
                                      coef_t want_peak);
        stim_row_t row;
        row = '0;
        row.kind = ROW_COEF;
        row.value = v;
        row.fixed = 1'b1;
        row.want.value = want_out;
        row.want.index = 6'd0;
        row.want.last = 1'b1;
        row.want.stable = want_stable;
        row.want.peak = want_peak;
        directed_rows.push_back(row);
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("%0t: mismatch: %s", $realtime, msg);
    endtask

    task automatic check_result();
        scaled_coef_t want;
        if (awaited_coefficients.size() == 0) begin
            report_mismatch($sformatf("result without expectation, index %0d value %h",
                                      m_coefficient_index, m_coefficient_out));
        end else begin
            want = awaited_coefficients.pop_front();
            if (m_coefficient_out !== want.value)
                report_mismatch($sformatf("coefficient_out index %0d: got %h expected %h",
                                          want.index, m_coefficient_out, want.value));
            if (m_coefficient_index !== want.index)
                report_mismatch($sformatf("coefficient_index: got %0d expected %0d",
                                          m_coefficient_index, want.index));
            if (m_is_last !== want.last)
                report_mismatch($sformatf("is_last index %0d: got %b expected %b",
                                          want.index, m_is_last, want.last));
            if (m_stable !== want.stable)
                report_mismatch($sformatf("stable index %0d: got %b expected %b",
                                          want.index, m_stable, want.stable));
            if (m_peak_amplitude !== want.peak)
                report_mismatch($sformatf("peak_amplitude index %0d: got %h expected %h",
                                          want.index, m_peak_amplitude, want.peak));
        end
    endtask

    task automatic check_register(input logic [1:0] idx, input logic [31:0] want);
        logic [31:0] got;
        logic [31:0] mask;
        case (idx)
            REG_FILTER_ORDER: mask = 32'h0000_003F;
            REG_WARP_ALPHA:   mask = 32'h0000_FFFF;
            default:          mask = 32'h7FFF_FFFF;
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_W'({idx, 2'b00});
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        if ((got & mask) !== (want & mask))
            report_mismatch($sformatf("register %0d reads %h expected %h",
                                      idx, got & mask, want & mask));
    endtask

    task automatic program_register(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        mirror_register_write(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        check_register(idx, value);
    endtask

    // Hold the input, drain all results, then let the front end finish its last coefficient.
    task automatic settle_for_write();
        s_valid <= 1'b0;
        while (awaited_coefficients.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic offer_coefficient(input coef_t c, input logic fixed,
                                     input scaled_coef_t want);
        s_valid       <= 1'b1;
        s_coefficient <= c;
        do @(posedge aclk); while (!s_ready);
        load_and_scale(c);
        foreach (frame_emission[i])
            awaited_coefficients.push_back(fixed ? want : frame_emission[i]);
        if ($urandom_range(99) < s_idle_pct) begin
            s_valid       <= 1'b0;
            s_coefficient <= coef_t'($urandom());
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
    endtask

    // receiver: check every transfer, pick ready for the next cycle, hold it low on request
    initial begin : result_side
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) check_result();
            if (hold_request) begin
                m_ready <= 1'b0;
                hold_request = 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_ready <= ($urandom_range(99) >= r_idle_pct);
            end
        end
    end

    initial begin : stimulus
        int          count;
        int          frames;
        int          items;
        logic [31:0] order_v;
        logic [31:0] alpha_v;
        logic [31:0] thr_v;
        logic [15:0] alpha_raw;

        aresetn       <= 1'b0;
        s_valid       <= 1'b0;
        s_coefficient <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        s_idle_pct   = 27;
        r_idle_pct   = 70;
        hold_request = 1'b0;

        restart_frame();
        ratio_q31     = '0;
        frame_ok      = 1'b1;
        order_reg     = RST_FILTER_ORDER;
        alpha_reg     = RST_WARP_ALPHA;
        threshold_reg = RST_PEAK_THRESHOLD;

        // order zero passes each coefficient through
        add_write(REG_FILTER_ORDER, 32'd0);
        add_fixed(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1, 32'sd0);
        add_fixed(32'sh8000_0000, 32'sh8000_0000, 1'b1, 32'sd0);
        add_fixed(32'shFFFF_FFFF, 32'shFFFF_FFFF, 1'b1, 32'sd0);
        add_fixed(32'sh5555_5555, 32'sh5555_5555, 1'b1, 32'sd0);
        add_fixed(32'shAAAA_AAAA, 32'shAAAA_AAAA, 1'b1, 32'sd0);
        // no warping: peak is c1; one stable frame, one scaled frame
        add_write(REG_FILTER_ORDER, 32'd1);
        add_write(REG_WARP_ALPHA, 32'd0);
        add_coef(32'sh0010_0000);
        add_coef(32'sh0010_0000);
        add_coef(32'sh0010_0000);
        add_coef(32'sh7FFF_FFFF);
        // zero threshold: ratio of zero, and a peak of exactly zero
        add_write(REG_PEAK_THRESHOLD, 32'd0);
        add_coef(32'sh0030_0000);
        add_coef(32'sd1);
        add_coef(32'sd5);
        add_coef(32'sd0);
        // -alpha of exactly one, largest threshold
        add_write(REG_WARP_ALPHA, 32'hFFFF_8000);
        add_write(REG_PEAK_THRESHOLD, 32'h7FFF_FFFF);
        add_write(REG_FILTER_ORDER, 32'd2);
        add_coef(32'sh8000_0000);
        add_coef(32'sh7FFF_FFFF);
        add_coef(32'sh1234_5678);
        // peak saturates high against the smallest nonzero threshold
        add_write(REG_WARP_ALPHA, 32'd32767);
        add_write(REG_PEAK_THRESHOLD, 32'd1);
        add_coef(32'sd0);
        add_coef(32'sh7FFF_FFFF);
        add_coef(32'sd0);
        // partial frame dropped by the next write
        add_coef(32'sd7);
        add_write(REG_FILTER_ORDER, 32'd5);

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        check_register(REG_FILTER_ORDER, 32'(RST_FILTER_ORDER));
        check_register(REG_WARP_ALPHA, 32'(RST_WARP_ALPHA));
        check_register(REG_PEAK_THRESHOLD, 32'(RST_PEAK_THRESHOLD));

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_WRITE) begin
                settle_for_write();
                program_register(directed_rows[i].reg_index, directed_rows[i].value);
            end else begin
                offer_coefficient(coef_t'(directed_rows[i].value), directed_rows[i].fixed,
                                  directed_rows[i].want);
            end
        end

        for (int phase = 0; phase < 9; phase++) begin
            settle_for_write();
            s_idle_pct = (phase < 3) ? 27 : (phase < 6) ? 70 : 0;
            r_idle_pct = (phase < 3) ? 70 : (phase < 6) ? 27 : 0;

            if (phase == 0) order_v = 32'd0;
            else if (phase == 4) order_v = 32'd63;
            else if (phase == 6) order_v = 32'd3;
            else order_v = $urandom_range(1, 7);

            alpha_raw = 16'($urandom());
            case ($urandom_range(4))
                0: alpha_v = 32'hFFFF_8000;
                1: alpha_v = 32'hFFFF_8001;
                2: alpha_v = 32'd32767;
                3: alpha_v = 32'd0;
                default: alpha_v = {{16{alpha_raw[15]}}, alpha_raw};
            endcase

            case ($urandom_range(4))
                0: thr_v = 32'd1;
                1: thr_v = 32'h7FFF_FFFF;
                2: thr_v = $urandom_range(1, 32'h0200_0000);
                default: thr_v = $urandom() & 32'h7FFF_FFFF;
            endcase

            program_register(REG_FILTER_ORDER, order_v);
            program_register(REG_WARP_ALPHA, alpha_v);
            program_register(REG_PEAK_THRESHOLD, thr_v);

            count = int'(order_v) + 1;
            frames = (4 + count - 1) / count;
            items = frames * count;
            // sometimes stop mid-frame so the next write drops it
            if (count > 1 && phase != 4 && phase != 6 && $urandom_range(3) == 0)
                items += $urandom_range(1, count - 1);
            if (phase == 6) begin
                items = 16;
                hold_request = 1'b1;
            end
            repeat (items) offer_coefficient(draw_coefficient(), 1'b0, '0);
        end

        s_valid <= 1'b0;
        while (awaited_coefficients.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
